// File: design/bmd_pkg.sv
// bmd_pkg: shared types, constants and circle tables of the button mouse delta generator
// no dependencies; imported by the channel interfaces and the top level
package bmd_pkg;

    localparam int unsigned CIRCLE_PERIOD_MS = 6283;
    localparam int unsigned HOLD_TIMER_MAX   = 2047;
    localparam int unsigned PHASE_W          = 13;
    localparam int unsigned TIMER_W          = 11;
    localparam int unsigned DEB_W            = 8;
    localparam int unsigned DELTA_W          = 4;
    localparam int unsigned CFG_IDX_W        = 2;
    localparam int unsigned CFG_DATA_W       = 11;
    localparam int unsigned NUM_DIR          = 4;
    localparam int unsigned NUM_SEG          = 11;

    localparam logic [DEB_W-1:0]   DEBOUNCE_RESET = 8'd30;
    localparam logic [TIMER_W-1:0] LEVEL2_RESET   = 11'd500;
    localparam logic [TIMER_W-1:0] LEVEL3_RESET   = 11'd1000;
    localparam logic [TIMER_W-1:0] LEVEL4_RESET   = 11'd1500;

    typedef enum logic [1:0] {
        DB_IDLE    = 2'd0,
        DB_CONFIRM = 2'd1,
        DB_WAIT    = 2'd2,
        DB_QUIET   = 2'd3
    } t_db_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_LEVEL2   = 2'd1,
        CFG_LEVEL3   = 2'd2,
        CFG_LEVEL4   = 2'd3
    } t_cfg_idx;

    typedef logic signed [DELTA_W-1:0] t_delta;

    typedef struct packed {
        logic up_level;
        logic down_level;
        logic left_level;
        logic right_level;
        logic mode_level;
    } t_in_beat;

    typedef logic [PHASE_W-1:0] t_bound_arr [NUM_SEG];
    typedef t_delta             t_val_arr   [NUM_SEG];

    localparam t_bound_arr COS_BOUND = '{13'd841, 13'd1230, 13'd1910, 13'd2300, 13'd3982,
        13'd4372, 13'd5052, 13'd5442, 13'd7124, 13'd7514, 13'd8191};
    localparam t_val_arr COS_VAL = '{4'sd2, 4'sd1, 4'sd0, -4'sd1, -4'sd2, -4'sd1, 4'sd0,
        4'sd1, 4'sd2, 4'sd1, 4'sd0};
    localparam t_bound_arr SIN_BOUND = '{13'd339, 13'd729, 13'd2411, 13'd2801, 13'd3481,
        13'd3871, 13'd5553, 13'd5943, 13'd6623, 13'd7012, 13'd8191};
    localparam t_val_arr SIN_VAL = '{4'sd0, 4'sd1, 4'sd2, 4'sd1, 4'sd0, -4'sd1, -4'sd2,
        -4'sd1, 4'sd0, 4'sd1, 4'sd2};

    // piecewise constant lookup, first segment whose bound is not below t
    function automatic t_delta seg_lookup(input t_bound_arr bound, input t_val_arr val,
                                          input logic [PHASE_W-1:0] t);
        t_delta res;
        res = val[NUM_SEG-1];
        for (int i = NUM_SEG - 1; i >= 0; i--) begin
            if (t <= bound[i]) begin
                res = val[i];
            end
        end
        return res;
    endfunction

    function automatic t_delta circle_x(input logic [PHASE_W-1:0] t);
        t_delta res;
        if (t == '0) begin
            res = 4'sd3;
        end else begin
            res = seg_lookup(COS_BOUND, COS_VAL, t);
        end
        return res;
    endfunction

    function automatic t_delta circle_y(input logic [PHASE_W-1:0] t);
        return seg_lookup(SIN_BOUND, SIN_VAL, t);
    endfunction

endpackage

// File: design/bmd_if.sv
// bmd_if: valid/ready channel interfaces for tick input, delta output and config writes
// depends on bmd_pkg
interface bmd_in_if
    import bmd_pkg::*;
    ();
    logic valid;
    logic ready;
    logic up_level;
    logic down_level;
    logic left_level;
    logic right_level;
    logic mode_level;

    modport source (output valid, up_level, down_level, left_level, right_level, mode_level,
                    input ready);
    modport sink   (input valid, up_level, down_level, left_level, right_level, mode_level,
                    output ready);
endinterface

interface bmd_out_if
    import bmd_pkg::*;
    ();
    logic   valid;
    logic   ready;
    t_delta move_x;
    t_delta move_y;
    logic   circle_mode;

    modport source (output valid, move_x, move_y, circle_mode, input ready);
    modport sink   (input valid, move_x, move_y, circle_mode, output ready);
endinterface

interface bmd_cfg_if
    import bmd_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/button_mouse_delta_generator_top.sv
// button_mouse_delta_generator_top: mouse keys with hold acceleration and circle mode
// depends on bmd_pkg and the channel interfaces in bmd_if
//
// usage:
//   in_ch carries one beat per millisecond tick: five active-low button levels
//   (up, down, left, right, mode). out_ch returns one beat per tick with move_x,
//   move_y (signed deltas) and circle_mode. cfg_ch writes debounce_ticks (index 0)
//   and the three hold thresholds (indexes 1 to 3); it is always ready and must be
//   written only while the block is idle, which the block itself does not enforce.
//   a tick beat is registered in the input register on acceptance, and its result
//   is registered in the result register when that register is empty or out_ch
//   takes its beat; the state update between the two registers is combinational.
//   throughput: one tick per cycle while out_ch does not stall the result register.
//   reset: all state clears to button mode with zero deltas and released buttons,
//   config registers return to 30 / 500 / 1000 / 1500 ms, no beat is held.
//   stall: a waiting result holds in the output register while one more tick
//   waits in the input register; in_ch ready drops once both are full.
module button_mouse_delta_generator_top
    import bmd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmd_in_if.sink     in_ch,
    bmd_out_if.source  out_ch,
    bmd_cfg_if.sink    cfg_ch
);

    logic [DEB_W-1:0]   r_debounce_ticks;
    logic [TIMER_W-1:0] r_level2, r_level3, r_level4;

    logic               r_in_valid;
    t_in_beat           r_in;
    logic               r_out_valid;
    t_delta             r_move_x, r_move_y;
    logic               r_circle;

    logic [NUM_DIR-1:0] r_held,  n_held;
    logic [TIMER_W-1:0] r_timer [NUM_DIR];
    logic [TIMER_W-1:0] n_timer [NUM_DIR];
    t_delta             r_dx, n_dx, r_dy, n_dy;
    logic               r_mode, n_mode;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [DEB_W-1:0]   r_db_count, n_db_count;
    t_db_phase          r_db_phase, n_db_phase;

    logic               advance;
    logic [NUM_DIR-1:0] pressed;

    assign advance      = r_in_valid && (!r_out_valid || out_ch.ready);
    assign in_ch.ready  = !r_in_valid || advance;
    assign cfg_ch.ready = 1'b1;

    assign out_ch.valid       = r_out_valid;
    assign out_ch.move_x      = r_move_x;
    assign out_ch.move_y      = r_move_y;
    assign out_ch.circle_mode = r_circle;

    assign pressed = {!r_in.right_level, !r_in.left_level, !r_in.down_level, !r_in.up_level};

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= DEBOUNCE_RESET;
            r_level2         <= LEVEL2_RESET;
            r_level3         <= LEVEL3_RESET;
            r_level4         <= LEVEL4_RESET;
        end else if (cfg_ch.valid) begin
            unique case (t_cfg_idx'(cfg_ch.index))
                CFG_DEBOUNCE: r_debounce_ticks <= cfg_ch.data[DEB_W-1:0];
                CFG_LEVEL2:   r_level2 <= cfg_ch.data[TIMER_W-1:0];
                CFG_LEVEL3:   r_level3 <= cfg_ch.data[TIMER_W-1:0];
                CFG_LEVEL4:   r_level4 <= cfg_ch.data[TIMER_W-1:0];
                default:      r_level4 <= r_level4;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ch.ready) begin
            r_in_valid <= in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.ready && in_ch.valid) begin
            r_in <= '{up_level: in_ch.up_level, down_level: in_ch.down_level,
                      left_level: in_ch.left_level, right_level: in_ch.right_level,
                      mode_level: in_ch.mode_level};
        end
    end

    // next state for one tick
    always_comb begin
        logic                run;
        logic [2:0]          lvl;
        t_delta              mag;
        t_delta              val;
        n_held     = r_held;
        n_timer    = r_timer;
        n_dx       = r_dx;
        n_dy       = r_dy;
        n_mode     = r_mode;
        n_db_count = r_db_count;
        n_db_phase = r_db_phase;
        run        = 1'b0;
        lvl        = 3'd1;
        mag        = '0;
        val        = '0;

        for (int i = 0; i < NUM_DIR; i++) begin
            if (r_held[i] && (r_timer[i] < TIMER_W'(HOLD_TIMER_MAX))) begin
                n_timer[i] = r_timer[i] + 1'b1;
            end
        end
        if ({1'b0, r_phase} + 1'b1 >= (PHASE_W+1)'(CIRCLE_PERIOD_MS)) begin
            n_phase = '0;
        end else begin
            n_phase = r_phase + 1'b1;
        end

        unique case (r_db_phase)
            DB_IDLE: begin
                if (!r_in.mode_level) begin
                    n_db_phase = DB_CONFIRM;
                    n_db_count = r_debounce_ticks;
                end else begin
                    run = 1'b1;
                end
            end
            DB_CONFIRM: begin
                if (r_db_count <= DEB_W'(1)) begin
                    n_db_count = '0;
                    if (!r_in.mode_level) begin
                        n_mode     = !r_mode;
                        n_dx       = '0;
                        n_dy       = '0;
                        n_phase    = '0;
                        n_db_phase = DB_WAIT;
                    end else begin
                        n_db_phase = DB_IDLE;
                        run        = 1'b1;
                    end
                end else begin
                    n_db_count = r_db_count - 1'b1;
                end
            end
            DB_WAIT: begin
                if (r_in.mode_level) begin
                    n_db_phase = DB_QUIET;
                    n_db_count = r_debounce_ticks;
                end
            end
            DB_QUIET: begin
                if (r_db_count <= DEB_W'(1)) begin
                    n_db_count = '0;
                    n_db_phase = DB_IDLE;
                    run        = 1'b1;
                end else begin
                    n_db_count = r_db_count - 1'b1;
                end
            end
            default: n_db_phase = DB_IDLE;
        endcase

        if (run) begin
            if (r_mode) begin
                n_dx = circle_x(n_phase);
                n_dy = circle_y(n_phase);
            end else begin
                // scan up, down, left, right; later buttons win on an axis
                for (int i = 0; i < NUM_DIR; i++) begin
                    if (n_timer[i] > r_level4) begin
                        lvl = 3'd4;
                    end else if (n_timer[i] > r_level3) begin
                        lvl = 3'd3;
                    end else if (n_timer[i] > r_level2) begin
                        lvl = 3'd2;
                    end else begin
                        lvl = 3'd1;
                    end
                    if (pressed[i] && !n_held[i]) begin
                        mag        = 4'sd1;
                        n_held[i]  = 1'b1;
                        n_timer[i] = '0;
                    end else if (pressed[i]) begin
                        mag = t_delta'({1'b0, lvl});
                    end else begin
                        mag = '0;
                    end
                    // up and left are negative
                    val = ((i % 2) == 0) ? -mag : mag;
                    if (pressed[i] || n_held[i]) begin
                        if (i < 2) begin
                            n_dy = val;
                        end else begin
                            n_dx = val;
                        end
                    end
                    if (!pressed[i]) begin
                        n_held[i] = 1'b0;
                    end
                end
            end
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_timer     <= '{default: '0};
            r_dx        <= '0;
            r_dy        <= '0;
            r_mode      <= 1'b0;
            r_phase     <= '0;
            r_db_count  <= '0;
            r_db_phase  <= DB_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_held      <= n_held;
                r_timer     <= n_timer;
                r_dx        <= n_dx;
                r_dy        <= n_dy;
                r_mode      <= n_mode;
                r_phase     <= n_phase;
                r_db_count  <= n_db_count;
                r_db_phase  <= n_db_phase;
                r_out_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_move_x <= n_dx;
            r_move_y <= n_dy;
            r_circle <= n_mode;
        end
    end

endmodule

// File: test/bmd_checker.sv
// bmd_checker: watches the tick, result and config channels of the mouse delta generator
// keeps its own copy of the hold timers, debounce machine and circle phase, checks every result
// depends on bmd_pkg and the channel interfaces in bmd_if
`timescale 1ns / 1ps

module bmd_checker
    import bmd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bmd_in_if    in_ch,
    bmd_out_if   out_ch,
    bmd_cfg_if   cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        t_delta move_x;
        t_delta move_y;
        logic   circle_mode;
    } t_motion;

    logic [DEB_W-1:0]   debounce_ticks;
    logic [TIMER_W-1:0] lvl2_after;
    logic [TIMER_W-1:0] lvl3_after;
    logic [TIMER_W-1:0] lvl4_after;

    logic               btn_held [NUM_DIR];
    logic [TIMER_W-1:0] hold_ms  [NUM_DIR];
    t_delta             dx;
    t_delta             dy;
    logic               circle_on;
    logic [PHASE_W-1:0] phase_ms;
    logic [DEB_W-1:0]   db_left;
    t_db_phase          db_state;

    t_motion            motion_q [$];

    function automatic t_delta ring_x(input logic [PHASE_W-1:0] t);
        return t_delta'($rtoi(3.0 * $cos(real'(t) / 1000.0)));
    endfunction

    function automatic t_delta ring_y(input logic [PHASE_W-1:0] t);
        return t_delta'($rtoi(3.0 * $sin(real'(t) / 1000.0)));
    endfunction

    task automatic clear_model();
        debounce_ticks = DEBOUNCE_RESET;
        lvl2_after     = LEVEL2_RESET;
        lvl3_after     = LEVEL3_RESET;
        lvl4_after     = LEVEL4_RESET;
        for (int i = 0; i < NUM_DIR; i++) begin
            btn_held[i] = 1'b0;
            hold_ms[i]  = '0;
        end
        dx        = '0;
        dy        = '0;
        circle_on = 1'b0;
        phase_ms  = '0;
        db_left   = '0;
        db_state  = DB_IDLE;
        motion_q.delete();
    endtask

    // scan order up, down, left, right; later buttons override earlier ones on an axis
    task automatic scan_dirs(input t_in_beat b);
        logic   dir_low [NUM_DIR];
        int     spd;
        t_delta step;
        dir_low[0] = !b.up_level;
        dir_low[1] = !b.down_level;
        dir_low[2] = !b.left_level;
        dir_low[3] = !b.right_level;
        for (int i = 0; i < NUM_DIR; i++) begin
            spd = -1;
            if (dir_low[i] && !btn_held[i]) begin
                spd         = 1;
                btn_held[i] = 1'b1;
                hold_ms[i]  = '0;
            end else if (dir_low[i]) begin
                if (hold_ms[i] > lvl4_after) begin
                    spd = 4;
                end else if (hold_ms[i] > lvl3_after) begin
                    spd = 3;
                end else if (hold_ms[i] > lvl2_after) begin
                    spd = 2;
                end else begin
                    spd = 1;
                end
            end else if (btn_held[i]) begin
                spd         = 0;
                btn_held[i] = 1'b0;
            end
            if (spd >= 0) begin
                step = t_delta'((i % 2 == 0) ? -spd : spd);
                if (i < 2) begin
                    dy = step;
                end else begin
                    dx = step;
                end
            end
        end
    endtask

    task automatic take_tick(input t_in_beat b);
        logic    mode_low;
        logic    run;
        t_motion m;
        mode_low = !b.mode_level;
        run      = 1'b0;
        for (int i = 0; i < NUM_DIR; i++) begin
            if (btn_held[i] && hold_ms[i] < HOLD_TIMER_MAX) begin
                hold_ms[i] = hold_ms[i] + 1'b1;
            end
        end
        if (phase_ms >= CIRCLE_PERIOD_MS - 1) begin
            phase_ms = '0;
        end else begin
            phase_ms = phase_ms + 1'b1;
        end
        case (db_state)
            DB_IDLE: begin
                if (mode_low) begin
                    db_state = DB_CONFIRM;
                    db_left  = debounce_ticks;
                end else begin
                    run = 1'b1;
                end
            end
            DB_CONFIRM: begin
                if (db_left <= 1) begin
                    db_left = '0;
                    if (mode_low) begin
                        circle_on = !circle_on;
                        dx        = '0;
                        dy        = '0;
                        phase_ms  = '0;
                        db_state  = DB_WAIT;
                    end else begin
                        db_state = DB_IDLE;
                        run      = 1'b1;
                    end
                end else begin
                    db_left = db_left - 1'b1;
                end
            end
            DB_WAIT: begin
                if (!mode_low) begin
                    db_state = DB_QUIET;
                    db_left  = debounce_ticks;
                end
            end
            default: begin
                if (db_left <= 1) begin
                    db_left  = '0;
                    db_state = DB_IDLE;
                    run      = 1'b1;
                end else begin
                    db_left = db_left - 1'b1;
                end
            end
        endcase
        if (run) begin
            if (circle_on) begin
                dx = (phase_ms == '0) ? t_delta'(3) : ring_x(phase_ms);
                dy = ring_y(phase_ms);
            end else begin
                scan_dirs(b);
            end
        end
        m.move_x      = dx;
        m.move_y      = dy;
        m.circle_mode = circle_on;
        motion_q.push_back(m);
    endtask

    task automatic compare_field(input string fname, input logic signed [DELTA_W:0] exp_v,
                                 input logic signed [DELTA_W:0] act_v);
        if (act_v !== exp_v) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_motion exp_m;
        if (!i_rst_n) begin
            clear_model();
            o_fail_count = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (motion_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result beat with nothing expected, x %0d y %0d circle %0b",
                             $time, out_ch.move_x, out_ch.move_y, out_ch.circle_mode);
                end else begin
                    exp_m = motion_q.pop_front();
                    compare_field("move_x", exp_m.move_x, out_ch.move_x);
                    compare_field("move_y", exp_m.move_y, out_ch.move_y);
                    compare_field("circle_mode", {4'b0, exp_m.circle_mode},
                                  {4'b0, out_ch.circle_mode});
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    CFG_DEBOUNCE: debounce_ticks = cfg_ch.data[DEB_W-1:0];
                    CFG_LEVEL2:   lvl2_after     = cfg_ch.data;
                    CFG_LEVEL3:   lvl3_after     = cfg_ch.data;
                    default:      lvl4_after     = cfg_ch.data;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                take_tick(t_in_beat'({in_ch.up_level, in_ch.down_level, in_ch.left_level,
                                      in_ch.right_level, in_ch.mode_level}));
            end
        end
        o_pending = motion_q.size();
    end

endmodule

// File: test/tb.sv
// tb: stimulus and verdict for button_mouse_delta_generator_top
// drives button ticks with random gaps and result back-pressure, and config writes; checking is done in bmd_checker
// depends on bmd_pkg, bmd_if and bmd_checker
`timescale 1ns / 1ps

module tb;
    import bmd_pkg::*;

    localparam logic [NUM_DIR-1:0] DIR_NONE  = 4'b0000;
    localparam logic [NUM_DIR-1:0] DIR_UP    = 4'b1000;
    localparam logic [NUM_DIR-1:0] DIR_DOWN  = 4'b0100;
    localparam logic [NUM_DIR-1:0] DIR_LEFT  = 4'b0010;
    localparam logic [NUM_DIR-1:0] DIR_RIGHT = 4'b0001;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   gaps_on;
    bit   in_gaps;
    int   tick_count;
    int   cur_db_eff;
    int   hold_cap;
    logic last_circle = 1'b0;

    bmd_in_if  in_ch ();
    bmd_out_if out_ch ();
    bmd_cfg_if cfg_ch ();

    button_mouse_delta_generator_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch)
    );

    bmd_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) begin
            last_circle <= out_ch.circle_mode;
        end
    end

    // result side back-pressure
    always begin
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            out_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 30)) @(negedge i_clk);
    end

    // dirs and mode_press are 1 for a pressed button; the pins are active low
    task automatic send_tick(input logic [NUM_DIR-1:0] dirs, input logic mode_press);
        in_ch.valid <= 1'b1;
        {in_ch.up_level, in_ch.down_level, in_ch.left_level, in_ch.right_level,
         in_ch.mode_level} <= ~{dirs, mode_press};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        tick_count++;
        @(negedge i_clk);
        if (in_gaps && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
    endtask

    task automatic send_ticks(input logic [NUM_DIR-1:0] dirs, input logic mode_press,
                              input int n);
        repeat (n) send_tick(dirs, mode_press);
    endtask

    task automatic quiesce();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_config(input int db, input int l2, input int l3, input int l4);
        logic [CFG_DATA_W-1:0] vals [4];
        int                    top_lvl;
        vals[CFG_DEBOUNCE] = CFG_DATA_W'(db);
        vals[CFG_LEVEL2]   = CFG_DATA_W'(l2);
        vals[CFG_LEVEL3]   = CFG_DATA_W'(l3);
        vals[CFG_LEVEL4]   = CFG_DATA_W'(l4);
        for (int k = 0; k < 4; k++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= t_cfg_idx'(k);
            cfg_ch.data  <= vals[k];
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
        cur_db_eff = (db == 0) ? 1 : db;
        top_lvl = (l2 > l3) ? l2 : l3;
        top_lvl = (l4 > top_lvl) ? l4 : top_lvl;
        hold_cap = ((top_lvl > 70) ? 70 : top_lvl) + 6;
    endtask

    task automatic mode_press(input logic [NUM_DIR-1:0] dirs);
        send_ticks(dirs, 1'b1, cur_db_eff + $urandom_range(1, 3));
        send_ticks(dirs, 1'b0, cur_db_eff + $urandom_range(1, 3));
    endtask

    task automatic rand_sequence();
        logic [NUM_DIR-1:0] dirs;
        int                 len;
        in_gaps = gaps_on && ($urandom_range(0, 2) != 0);
        dirs = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                len = $urandom_range(1, hold_cap);
                repeat (len) begin
                    if ($urandom_range(0, 9) == 0) begin
                        dirs = 4'($urandom_range(0, 15));
                    end
                    send_tick(dirs, 1'b0);
                end
            end
            4, 5: begin
                mode_press(dirs);
            end
            6: begin
                // mode released before the debounce time runs out
                send_ticks(dirs, 1'b1, $urandom_range(1, cur_db_eff));
                send_ticks(dirs, 1'b0, $urandom_range(1, 3));
            end
            7: begin
                repeat ($urandom_range(10, 60)) send_tick(4'($urandom_range(0, 15)), 1'b0);
            end
            default: begin
                repeat ($urandom_range(1, 5)) begin
                    send_tick(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
                end
            end
        endcase
    endtask

    task automatic rand_phase(input int n);
        int start;
        start = tick_count;
        while (tick_count - start < n) rand_sequence();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        gaps_on          = 1'b0;
        in_gaps          = 1'b0;
        tick_count       = 0;
        cur_db_eff       = 30;
        hold_cap         = 76;
        in_ch.valid      = 1'b0;
        in_ch.up_level   = 1'b1;
        in_ch.down_level = 1'b1;
        in_ch.left_level = 1'b1;
        in_ch.right_level = 1'b1;
        in_ch.mode_level = 1'b1;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_DEBOUNCE;
        cfg_ch.data      = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed
        set_config(2, 3, 6, 9);
        send_ticks(DIR_NONE, 1'b0, 1);
        send_ticks(DIR_UP, 1'b0, 10);
        send_ticks(DIR_UP | DIR_DOWN, 1'b0, 2);
        send_ticks(DIR_DOWN, 1'b0, 1);
        send_ticks(DIR_LEFT | DIR_RIGHT, 1'b0, 1);
        send_ticks(DIR_NONE, 1'b0, 1);
        send_ticks(DIR_NONE, 1'b1, 4);
        send_ticks(DIR_RIGHT, 1'b0, 3);
        send_ticks(DIR_NONE, 1'b0, 2);
        send_ticks(DIR_NONE, 1'b1, 1);
        send_ticks(DIR_NONE, 1'b0, 3);

        // random, with gaps on both sides
        gaps_on = 1'b1;
        quiesce();
        set_config(1, 0, 0, 0);
        rand_phase(90);
        quiesce();
        set_config(0, 2, 5, 8);
        rand_phase(90);
        quiesce();
        set_config(4, 30, 10, 50);
        rand_phase(90);
        quiesce();
        set_config(40, 20, 40, 60);
        rand_phase(50);
        quiesce();
        set_config(3, 6, 12, 2046);
        rand_phase(90);

        // last part without gaps: hold levels and circle mode
        gaps_on = 1'b0;
        in_gaps = 1'b0;
        quiesce();
        set_config(1, 10, 20, 30);
        if (last_circle) begin
            mode_press(DIR_NONE);
        end
        send_ticks(DIR_UP | DIR_RIGHT, 1'b0, 40);
        send_ticks(DIR_NONE, 1'b0, 2);
        mode_press(DIR_NONE);
        repeat (60) send_tick(4'($urandom_range(0, 15)), 1'b0);
        mode_press(DIR_LEFT);

        quiesce();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
